>>> hw/rtl/banked_shift_register_output_controller_macros.svh
// ============================================================================
// Assertion macros for the banked shift register output controller
// Each checker is compiled in simulation and left empty for synthesis.
// ============================================================================
`ifndef BANKED_SHIFT_REGISTER_OUTPUT_CONTROLLER_MACROS_SVH
`define BANKED_SHIFT_REGISTER_OUTPUT_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check on a given clock, masked while reset is low.
`define BSROC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent check on the block clock and reset.
`define BSROC_ASSERT(lbl, prop, msg) `BSROC_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define BSROC_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define BSROC_ASSERT(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/bsroc_pkg.sv
// ============================================================================
// bsroc_pkg
// Shared types and constants of the banked shift register output controller.
// ============================================================================
package bsroc_pkg;

    // Number of bank size registers and the bank limit.
    localparam int BANK_REGS = 4;
    localparam int MAX_BANKS = 4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BANK_TOTAL  = 3'd0;
    localparam logic [2:0] CFG_BANK0_CHIPS = 3'd1;

    // Stream payload widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 16;

    typedef enum logic [3:0] {
        OP_SET_ALL,
        OP_INV_ALL,
        OP_SET_PIN,
        OP_INV_PIN,
        OP_READ_PIN,
        OP_SET_BANKS,
        OP_INV_BANKS,
        OP_SET_BPIN,
        OP_INV_BPIN,
        OP_READ_BPIN,
        OP_WRITE_CHIP,
        OP_INV_CHIP,
        OP_READ_CHIP,
        OP_BANK_OF_PIN,
        OP_PIN_COUNT,
        OP_SHIFT
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_PIN_RANGE,
        ST_NO_BANK,
        ST_NO_CHIP,
        ST_BAD_RANGE
    } status_t;

    // Bank layout derived from the configuration registers.
    typedef struct packed {
        logic [2:0]                def_banks;
        logic [BANK_REGS-1:0][3:0] bank_low;
        logic [BANK_REGS-1:0][3:0] bank_cnt;
        logic [6:0]                active_pins;
    } layout_t;

    // Controls from the sequencer to the bit shifter.
    typedef struct packed {
        logic       load;
        logic       advance;
        logic       msb_first;
        logic [7:0] load_byte;
    } shift_ctl_t;

    // Status from the bit shifter.
    typedef struct packed {
        logic data_bit;
        logic last_bit;
    } shift_stat_t;

endpackage

>>> hw/rtl/banked_shift_register_output_controller.sv
// ============================================================================
// banked_shift_register_output_controller
// Output image for cascaded 8-bit serial-in parallel-out chips in banks.
// ============================================================================
// Requests arrive on the s_ stream: the opcode in s_tuser, the operands in
// s_tdata. Results leave on the m_ stream; m_tuser flags a serial bit and
// m_tlast marks the final result of a request. Bank sizes are set through
// the cfg_ write port while no request is in flight.
// A request other than a shift is executed once accepted and loads its
// result into the output register when that register is free; only then
// does the block return to idle and take the next request. A shift streams
// its banks out: a load state fetches each chip byte from the image into the
// byte shifter, which then hands out one bit per cycle while m_tready does
// not hold the output register.
// The result sits in an output register, so a new request is accepted
// while the previous result still waits. When m_tready is low the result
// holds and the sequencer waits before producing the next one.
// Reset clears the image (all pins low), sets every bank to one chip and
// the bank count to zero, and empties the output register.
// ============================================================================
`include "banked_shift_register_output_controller_macros.svh"

module banked_shift_register_output_controller #(
    parameter int TOTAL_CHIPS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [3:0]                      cfg_wdata,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bank_first[1:0], bank_last[3:2], pin[9:4], chip[12:10], level[13],
    // byte_value[21:14], msb_first[22], zero[23]
    input  logic [bsroc_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[3:0]
    input  logic [bsroc_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], result_value[10:3], bank_line[12:11], serial_bit[13],
    // latch_pulse[14], zero[15]
    output logic [bsroc_pkg::M_TDATA_W-1:0] m_tdata,
    // is_shift_bit[0]
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int IDX_W = (TOTAL_CHIPS > 1) ? $clog2(TOTAL_CHIPS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_BITS
    } state_t;

    // Configuration registers
    logic [2:0]                           bank_total_reg;
    logic [bsroc_pkg::BANK_REGS-1:0][3:0] bank_chips_reg;
    bsroc_pkg::layout_t                   lay;

    // Request operands
    bsroc_pkg::opcode_t op_reg;
    logic [1:0]         bf_reg;
    logic [1:0]         bl_reg;
    logic [5:0]         pin_reg;
    logic [2:0]         chip_reg;
    logic               level_reg;
    logic [7:0]         byte_reg;
    logic               msb_reg;

    // Image and sequencer
    logic [7:0]         image_reg [TOTAL_CHIPS];
    logic [7:0]         img_next  [TOTAL_CHIPS];
    state_t             state_reg;
    logic [1:0]         sh_bank_reg;
    logic [2:0]         sh_chip_reg;

    // Output register
    logic               m_tvalid_reg;
    bsroc_pkg::status_t out_status_reg;
    logic [7:0]         out_value_reg;
    logic               out_shift_reg;
    logic [1:0]         out_line_reg;
    logic               out_bit_reg;
    logic               out_latch_reg;
    logic               out_last_reg;

    // Decode
    logic               bank_rel;
    logic [6:0]         abs_pin;
    logic               pin_ok;
    logic [3:0]         pin_byte;
    logic [IDX_W-1:0]   pin_idx;
    logic [7:0]         pin_mask;
    logic [7:0]         pin_new;
    logic               bf_def;
    logic               bl_def;
    logic               range_bad;
    logic [3:0]         range_lo;
    logic [3:0]         range_hi;
    logic               chip_ok;
    logic [3:0]         chip_slot;
    logic [IDX_W-1:0]   chip_idx;
    logic               found;
    logic [1:0]         found_bank;
    bsroc_pkg::status_t ex_status;
    logic [7:0]         ex_value;
    logic               out_free;
    logic               shift_go;
    logic               exec_fire;
    logic               out_load;

    // Shift walk
    logic [3:0]               sh_cnt;
    logic [3:0]               sh_slot;
    logic                     chip_last;
    logic                     bank_last;
    logic                     bit_latch;
    bsroc_pkg::shift_ctl_t    sh_ctl;
    bsroc_pkg::shift_stat_t   sh_stat;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_total_reg <= '0;
            for (int i = 0; i < bsroc_pkg::BANK_REGS; i++) begin
                bank_chips_reg[i] <= 4'd1;
            end
        end else if (cfg_we) begin
            if (cfg_index == bsroc_pkg::CFG_BANK_TOTAL) begin
                bank_total_reg <= cfg_wdata[2:0];
            end
            for (int i = 0; i < bsroc_pkg::BANK_REGS; i++) begin
                if (cfg_index == bsroc_pkg::CFG_BANK0_CHIPS + 3'(i)) begin
                    bank_chips_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    bsroc_layout #(
        .TOTAL_CHIPS (TOTAL_CHIPS)
    ) u_layout (
        .bank_total (bank_total_reg),
        .bank_chips (bank_chips_reg),
        .layout     (lay)
    );

    // Operand decode shared by the single-result requests.
    always_comb begin
        bank_rel  = (op_reg == bsroc_pkg::OP_SET_BPIN) ||
                    (op_reg == bsroc_pkg::OP_INV_BPIN) ||
                    (op_reg == bsroc_pkg::OP_READ_BPIN);
        abs_pin   = {1'b0, pin_reg} + (bank_rel ? {lay.bank_low[bf_reg], 3'b000} : 7'd0);
        pin_ok    = (abs_pin < lay.active_pins);
        pin_byte  = abs_pin[6:3];
        pin_idx   = pin_byte[IDX_W-1:0];
        pin_mask  = 8'd1 << abs_pin[2:0];
        pin_new   = image_reg[pin_idx] ^ pin_mask;
        bf_def    = ({1'b0, bf_reg} < lay.def_banks);
        bl_def    = ({1'b0, bl_reg} < lay.def_banks);
        range_bad = (bf_reg > bl_reg) || !bl_def;
        range_lo  = lay.bank_low[bf_reg];
        range_hi  = lay.bank_low[bl_reg] + lay.bank_cnt[bl_reg];
        chip_ok   = ({1'b0, chip_reg} < lay.bank_cnt[bf_reg]);
        chip_slot = lay.bank_low[bf_reg] + {1'b0, chip_reg};
        chip_idx  = chip_slot[IDX_W-1:0];
    end

    // Bank holding an absolute pin: the first defined bank ending past it.
    always_comb begin
        found      = 1'b0;
        found_bank = '0;
        for (int b = 0; b < bsroc_pkg::BANK_REGS; b++) begin
            if (!found && (3'(b) < lay.def_banks) &&
                ({1'b0, pin_reg[5:3]} < (lay.bank_low[b] + lay.bank_cnt[b]))) begin
                found      = 1'b1;
                found_bank = 2'(b);
            end
        end
    end

    // Result and image update of a single-result request.
    always_comb begin
        img_next  = image_reg;
        ex_status = bsroc_pkg::ST_OK;
        ex_value  = '0;
        unique case (op_reg)
            bsroc_pkg::OP_SET_ALL: begin
                for (int i = 0; i < TOTAL_CHIPS; i++) begin
                    img_next[i] = {8{level_reg}};
                end
            end
            bsroc_pkg::OP_INV_ALL: begin
                for (int i = 0; i < TOTAL_CHIPS; i++) begin
                    img_next[i] = ~image_reg[i];
                end
            end
            bsroc_pkg::OP_SET_PIN, bsroc_pkg::OP_SET_BPIN,
            bsroc_pkg::OP_INV_PIN, bsroc_pkg::OP_INV_BPIN,
            bsroc_pkg::OP_READ_PIN, bsroc_pkg::OP_READ_BPIN: begin
                if (bank_rel && !bf_def) begin
                    ex_status = bsroc_pkg::ST_NO_BANK;
                end else if (!pin_ok) begin
                    ex_status = bsroc_pkg::ST_PIN_RANGE;
                end else if ((op_reg == bsroc_pkg::OP_SET_PIN) ||
                             (op_reg == bsroc_pkg::OP_SET_BPIN)) begin
                    img_next[pin_idx] = level_reg ? (image_reg[pin_idx] | pin_mask)
                                                  : (image_reg[pin_idx] & ~pin_mask);
                    ex_value = {1'b0, abs_pin};
                end else if ((op_reg == bsroc_pkg::OP_INV_PIN) ||
                             (op_reg == bsroc_pkg::OP_INV_BPIN)) begin
                    img_next[pin_idx] = pin_new;
                    ex_value = {7'd0, |(pin_new & pin_mask)};
                end else begin
                    ex_value = {7'd0, |(image_reg[pin_idx] & pin_mask)};
                end
            end
            bsroc_pkg::OP_SET_BANKS, bsroc_pkg::OP_INV_BANKS: begin
                if (range_bad) begin
                    ex_status = bsroc_pkg::ST_BAD_RANGE;
                end else begin
                    for (int i = 0; i < TOTAL_CHIPS; i++) begin
                        if ((4'(i) >= range_lo) && (4'(i) < range_hi)) begin
                            img_next[i] = (op_reg == bsroc_pkg::OP_SET_BANKS) ?
                                          {8{level_reg}} : ~image_reg[i];
                        end
                    end
                end
            end
            bsroc_pkg::OP_WRITE_CHIP, bsroc_pkg::OP_INV_CHIP,
            bsroc_pkg::OP_READ_CHIP: begin
                if (!bf_def) begin
                    ex_status = bsroc_pkg::ST_NO_BANK;
                end else if (!chip_ok) begin
                    ex_status = bsroc_pkg::ST_NO_CHIP;
                end else if (op_reg == bsroc_pkg::OP_WRITE_CHIP) begin
                    img_next[chip_idx] = byte_reg;
                    ex_value = {4'd0, chip_slot};
                end else if (op_reg == bsroc_pkg::OP_INV_CHIP) begin
                    img_next[chip_idx] = ~image_reg[chip_idx];
                    ex_value = {4'd0, chip_slot};
                end else begin
                    ex_value = image_reg[chip_idx];
                end
            end
            bsroc_pkg::OP_BANK_OF_PIN: begin
                if (!pin_ok || !found) begin
                    ex_status = bsroc_pkg::ST_NO_BANK;
                end else begin
                    ex_value = {6'd0, found_bank};
                end
            end
            bsroc_pkg::OP_PIN_COUNT: begin
                if (!bf_def) begin
                    ex_status = bsroc_pkg::ST_NO_BANK;
                end else begin
                    ex_value = {1'b0, lay.bank_cnt[bf_reg], 3'b000};
                end
            end
            bsroc_pkg::OP_SHIFT: begin
                // Reaches the output only when the range is rejected.
                ex_status = bsroc_pkg::ST_BAD_RANGE;
            end
            default: begin
                ex_status = bsroc_pkg::ST_OK;
            end
        endcase
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign shift_go  = (op_reg == bsroc_pkg::OP_SHIFT) && !range_bad;
    assign exec_fire = (state_reg == ST_EXEC) && !shift_go && out_free;

    // Image store; only a finished single-result request changes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_CHIPS; i++) begin
                image_reg[i] <= '0;
            end
        end else if (exec_fire) begin
            image_reg <= img_next;
        end
    end

    // Chip byte addressed by the shift walk.
    always_comb begin
        sh_cnt    = lay.bank_cnt[sh_bank_reg];
        sh_slot   = msb_reg ? (lay.bank_low[sh_bank_reg] + sh_cnt - 4'd1 - {1'b0, sh_chip_reg})
                            : (lay.bank_low[sh_bank_reg] + {1'b0, sh_chip_reg});
        chip_last = ({1'b0, sh_chip_reg} == (sh_cnt - 4'd1));
        bank_last = (sh_bank_reg == bl_reg);
        bit_latch = sh_stat.last_bit && chip_last;
    end

    assign sh_ctl.load      = (state_reg == ST_LOAD);
    assign sh_ctl.advance   = (state_reg == ST_BITS) && out_free;
    assign sh_ctl.msb_first = msb_reg;
    assign sh_ctl.load_byte = image_reg[sh_slot[IDX_W-1:0]];

    // The output register takes a new result on these edges.
    assign out_load = exec_fire || sh_ctl.advance;

    bsroc_shifter u_shifter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sh_ctl),
        .stat    (sh_stat)
    );

    // Sequencer with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            sh_bank_reg  <= '0;
            sh_chip_reg  <= '0;
        end else begin
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= bsroc_pkg::opcode_t'(s_tuser);
                        bf_reg    <= s_tdata[1:0];
                        bl_reg    <= s_tdata[3:2];
                        pin_reg   <= s_tdata[9:4];
                        chip_reg  <= s_tdata[12:10];
                        level_reg <= s_tdata[13];
                        byte_reg  <= s_tdata[21:14];
                        msb_reg   <= s_tdata[22];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (shift_go) begin
                        sh_bank_reg <= bf_reg;
                        sh_chip_reg <= '0;
                        state_reg   <= ST_LOAD;
                    end else if (out_free) begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= ex_status;
                        out_value_reg  <= (ex_status == bsroc_pkg::ST_OK) ? ex_value : 8'd0;
                        out_shift_reg  <= 1'b0;
                        out_line_reg   <= '0;
                        out_bit_reg    <= 1'b0;
                        out_latch_reg  <= 1'b0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_BITS;
                end
                ST_BITS: begin
                    if (out_free) begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= bsroc_pkg::ST_OK;
                        out_value_reg  <= '0;
                        out_shift_reg  <= 1'b1;
                        out_line_reg   <= sh_bank_reg;
                        out_bit_reg    <= sh_stat.data_bit;
                        out_latch_reg  <= bit_latch;
                        out_last_reg   <= bit_latch && bank_last;
                        if (sh_stat.last_bit) begin
                            if (!chip_last) begin
                                sh_chip_reg <= sh_chip_reg + 3'd1;
                                state_reg   <= ST_LOAD;
                            end else if (!bank_last) begin
                                sh_bank_reg <= sh_bank_reg + 2'd1;
                                sh_chip_reg <= '0;
                                state_reg   <= ST_LOAD;
                            end else begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // No request is taken while reset is held.
    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_latch_reg, out_bit_reg, out_line_reg,
                       out_value_reg, out_status_reg};
    assign m_tuser  = out_shift_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `BSROC_ASSERT(a_accept_to_exec, (s_tvalid && s_tready) |=> (state_reg == ST_EXEC), "accepted request did not start")
    `BSROC_ASSERT(a_shift_bit_ok, (m_tvalid && m_tuser) |-> ((m_tdata[2:0] == 3'd0) && (m_tdata[10:3] == 8'd0)), "shift bit with status or value")
    `BSROC_ASSERT(a_plain_clean, (m_tvalid && !m_tuser) |-> ((m_tdata[14:11] == 4'd0) && m_tlast), "plain result carries shift lines")
    `BSROC_ASSERT(a_last_latches, (m_tvalid && m_tuser && m_tlast) |-> m_tdata[14], "final shift bit without latch")
    `BSROC_ASSERT(a_bits_in_range, (state_reg == ST_BITS) |-> ((sh_bank_reg >= bf_reg) && (sh_bank_reg <= bl_reg)), "shift walk left its bank range")

endmodule

>>> hw/rtl/bsroc_layout.sv
// ============================================================================
// bsroc_layout
// Walks the bank size registers and derives the defined banks, their first
// chip, their chip count and the number of active pins.
// ============================================================================
module bsroc_layout #(
    parameter int TOTAL_CHIPS = 8
) (
    input  logic [2:0]                           bank_total,
    input  logic [bsroc_pkg::BANK_REGS-1:0][3:0] bank_chips,
    output bsroc_pkg::layout_t                   layout
);

    logic [2:0] limit;
    logic [3:0] used;
    logic [4:0] trial;
    logic       run;

    // Banks are taken in order, up to the bank count, until one is empty or overflows the chips.
    always_comb begin
        limit  = (bank_total > 3'(bsroc_pkg::MAX_BANKS)) ? 3'(bsroc_pkg::MAX_BANKS)
                                                         : bank_total;
        used   = '0;
        trial  = '0;
        run    = 1'b1;
        layout = '0;
        for (int i = 0; i < bsroc_pkg::BANK_REGS; i++) begin
            trial = {1'b0, used} + {1'b0, bank_chips[i]};
            if (run && (3'(i) < limit) && (bank_chips[i] != 4'd0) &&
                (trial <= 5'(TOTAL_CHIPS))) begin
                layout.bank_low[i] = used;
                layout.bank_cnt[i] = bank_chips[i];
                used               = trial[3:0];
                layout.def_banks   = 3'(i + 1);
            end else begin
                run = 1'b0;
            end
        end
        layout.active_pins = {used, 3'b000};
    end

endmodule

>>> hw/rtl/bsroc_shifter.sv
// ============================================================================
// bsroc_shifter
// One byte shift register that hands out one serial bit per advance, LSB or
// MSB first, and flags the eighth bit.
// ============================================================================
module bsroc_shifter (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bsroc_pkg::shift_ctl_t  ctl,
    output bsroc_pkg::shift_stat_t stat
);

    logic [7:0] data_reg;
    logic [2:0] cnt_reg;
    logic       msb_reg;

    // Load a fresh byte or move one bit along.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctl.load) begin
            data_reg <= ctl.load_byte;
            msb_reg  <= ctl.msb_first;
            cnt_reg  <= '0;
        end else if (ctl.advance) begin
            data_reg <= msb_reg ? {data_reg[6:0], 1'b0} : {1'b0, data_reg[7:1]};
            cnt_reg  <= cnt_reg + 3'd1;
        end
    end

    // The bit on the line is the one at the leading end.
    assign stat.data_bit = msb_reg ? data_reg[7] : data_reg[0];
    assign stat.last_bit = (cnt_reg == 3'd7);

endmodule

>>> bench/bsroc_checker.sv
// ============================================================================
// bsroc_checker
// Watches the request, result and register-write ports of the banked shift
// register output controller. It keeps its own copy of the pin image and the
// bank registers, works out the results each accepted request must give, and
// compares every accepted result field by field with the oldest one waiting.
// ============================================================================
module bsroc_checker #(
    parameter int TOTAL_CHIPS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [3:0]                      cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // bank_first[1:0], bank_last[3:2], pin[9:4], chip[12:10], level[13],
    // byte_value[21:14], msb_first[22], zero[23]
    input  logic [bsroc_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[3:0]
    input  logic [bsroc_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], result_value[10:3], bank_line[12:11], serial_bit[13],
    // latch_pulse[14], zero[15]
    input  logic [bsroc_pkg::M_TDATA_W-1:0] m_tdata,
    // is_shift_bit[0]
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bsroc_pkg::status_t status;
        logic [7:0]         value;
        logic               shift;
        logic [1:0]         line;
        logic               sbit;
        logic               latch;
        logic               last;
    } pin_result_t;

    // Results still owed by the block, oldest first.
    pin_result_t pending_results[$];

    // Mirror of the pin image and the bank registers.
    logic [7:0] image [TOTAL_CHIPS];
    logic [2:0] bank_count_reg;
    logic [3:0] chips_reg [bsroc_pkg::BANK_REGS];

    // Bank layout derived from the registers.
    int defined_banks;
    int active_pins;
    int bank_base [bsroc_pkg::BANK_REGS];
    int bank_size [bsroc_pkg::BANK_REGS];

    // Banks count in order, up to the bank count, until one is empty or would overrun the chips.
    function automatic void derive_layout();
        int limit;
        int used;
        logic stop;
        limit = (bank_count_reg > bsroc_pkg::MAX_BANKS) ? bsroc_pkg::MAX_BANKS
                                                         : int'(bank_count_reg);
        used = 0;
        stop = 1'b0;
        defined_banks = 0;
        for (int b = 0; b < limit; b++) begin
            if (!stop) begin
                if (chips_reg[b] == 0 || used + int'(chips_reg[b]) > TOTAL_CHIPS) begin
                    stop = 1'b1;
                end else begin
                    bank_base[b] = used;
                    bank_size[b] = int'(chips_reg[b]);
                    used += int'(chips_reg[b]);
                    defined_banks = b + 1;
                end
            end
        end
        active_pins = used * 8;
    endfunction

    function automatic void queue_result(bsroc_pkg::status_t st, int value, logic shift,
                                         int line, logic sbit, logic latch, logic last);
        pin_result_t r;
        r.status = st;
        r.value  = (st == bsroc_pkg::ST_OK) ? value[7:0] : 8'd0;
        r.shift  = shift;
        r.line   = line[1:0];
        r.sbit   = sbit;
        r.latch  = latch;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void queue_single(bsroc_pkg::status_t st, int value);
        queue_result(st, value, 1'b0, 0, 1'b0, 1'b0, 1'b1);
    endfunction

    // Set, invert or read one absolute pin.
    function automatic void access_pin(bsroc_pkg::opcode_t kind, int p, logic lvl);
        int slot;
        logic [7:0] mask;
        if (p >= active_pins) begin
            queue_single(bsroc_pkg::ST_PIN_RANGE, 0);
        end else begin
            slot = p / 8;
            mask = 8'd1 << (p % 8);
            case (kind)
                bsroc_pkg::OP_SET_PIN: begin
                    image[slot] = lvl ? (image[slot] | mask) : (image[slot] & ~mask);
                    queue_single(bsroc_pkg::ST_OK, p);
                end
                bsroc_pkg::OP_INV_PIN: begin
                    image[slot] = image[slot] ^ mask;
                    queue_single(bsroc_pkg::ST_OK, int'((image[slot] & mask) != 0));
                end
                default: begin
                    queue_single(bsroc_pkg::ST_OK, int'((image[slot] & mask) != 0));
                end
            endcase
        end
    endfunction

    // Work out the results of one request and update the image.
    function automatic void model_request(bsroc_pkg::opcode_t op, logic [1:0] bf,
                                          logic [1:0] bl, logic [5:0] pin, logic [2:0] chip,
                                          logic lvl, logic [7:0] val, logic msb);
        int slot;
        int owner;
        int pos;
        logic endb;
        logic bad_range;
        logic bank_ok;
        logic [7:0] chip_bits;
        bsroc_pkg::opcode_t kind;
        derive_layout();
        bad_range = (bf > bl) || (int'(bl) >= defined_banks);
        bank_ok = (int'(bf) < defined_banks);
        case (op)
            bsroc_pkg::OP_SET_ALL: begin
                for (int i = 0; i < TOTAL_CHIPS; i++) image[i] = lvl ? 8'hff : 8'h00;
                queue_single(bsroc_pkg::ST_OK, 0);
            end
            bsroc_pkg::OP_INV_ALL: begin
                for (int i = 0; i < TOTAL_CHIPS; i++) image[i] = ~image[i];
                queue_single(bsroc_pkg::ST_OK, 0);
            end
            bsroc_pkg::OP_SET_PIN, bsroc_pkg::OP_INV_PIN, bsroc_pkg::OP_READ_PIN: begin
                access_pin(op, int'(pin), lvl);
            end
            bsroc_pkg::OP_SET_BANKS, bsroc_pkg::OP_INV_BANKS: begin
                if (bad_range) begin
                    queue_single(bsroc_pkg::ST_BAD_RANGE, 0);
                end else begin
                    for (int b = int'(bf); b <= int'(bl); b++) begin
                        for (int k = 0; k < bank_size[b]; k++) begin
                            slot = bank_base[b] + k;
                            if (op == bsroc_pkg::OP_SET_BANKS) image[slot] = lvl ? 8'hff : 8'h00;
                            else image[slot] = ~image[slot];
                        end
                    end
                    queue_single(bsroc_pkg::ST_OK, 0);
                end
            end
            bsroc_pkg::OP_SET_BPIN, bsroc_pkg::OP_INV_BPIN, bsroc_pkg::OP_READ_BPIN: begin
                // The offset pin is only checked against all active pins.
                if (!bank_ok) begin
                    queue_single(bsroc_pkg::ST_NO_BANK, 0);
                end else begin
                    kind = (op == bsroc_pkg::OP_SET_BPIN) ? bsroc_pkg::OP_SET_PIN :
                           (op == bsroc_pkg::OP_INV_BPIN) ? bsroc_pkg::OP_INV_PIN :
                                                            bsroc_pkg::OP_READ_PIN;
                    access_pin(kind, int'(pin) + bank_base[bf] * 8, lvl);
                end
            end
            bsroc_pkg::OP_WRITE_CHIP, bsroc_pkg::OP_INV_CHIP, bsroc_pkg::OP_READ_CHIP: begin
                if (!bank_ok) begin
                    queue_single(bsroc_pkg::ST_NO_BANK, 0);
                end else if (int'(chip) >= bank_size[bf]) begin
                    queue_single(bsroc_pkg::ST_NO_CHIP, 0);
                end else begin
                    slot = bank_base[bf] + int'(chip);
                    if (op == bsroc_pkg::OP_WRITE_CHIP) begin
                        image[slot] = val;
                        queue_single(bsroc_pkg::ST_OK, slot);
                    end else if (op == bsroc_pkg::OP_INV_CHIP) begin
                        image[slot] = ~image[slot];
                        queue_single(bsroc_pkg::ST_OK, slot);
                    end else begin
                        queue_single(bsroc_pkg::ST_OK, int'(image[slot]));
                    end
                end
            end
            bsroc_pkg::OP_BANK_OF_PIN: begin
                owner = -1;
                if (int'(pin) < active_pins) begin
                    for (int b = 0; b < defined_banks; b++) begin
                        if (int'(pin) >= bank_base[b] * 8 &&
                            int'(pin) < (bank_base[b] + bank_size[b]) * 8)
                            owner = b;
                    end
                end
                if (owner < 0) queue_single(bsroc_pkg::ST_NO_BANK, 0);
                else queue_single(bsroc_pkg::ST_OK, owner);
            end
            bsroc_pkg::OP_PIN_COUNT: begin
                if (!bank_ok) queue_single(bsroc_pkg::ST_NO_BANK, 0);
                else queue_single(bsroc_pkg::ST_OK, bank_size[bf] * 8);
            end
            default: begin
                // Shift: one result per bit, latch on the final bit of each bank.
                if (bad_range) begin
                    queue_single(bsroc_pkg::ST_BAD_RANGE, 0);
                end else begin
                    for (int b = int'(bf); b <= int'(bl); b++) begin
                        for (int k = 0; k < bank_size[b]; k++) begin
                            slot = msb ? bank_base[b] + bank_size[b] - 1 - k : bank_base[b] + k;
                            chip_bits = image[slot];
                            for (int i = 0; i < 8; i++) begin
                                pos = msb ? 7 - i : i;
                                endb = (k == bank_size[b] - 1) && (i == 7);
                                queue_result(bsroc_pkg::ST_OK, 0, 1'b1, b, chip_bits[pos], endb,
                                             endb && (b == int'(bl)));
                            end
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Register writes first, then the request, then the result of this edge.
    always @(posedge aclk) begin
        pin_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_CHIPS; i++) image[i] = 8'h00;
            for (int b = 0; b < bsroc_pkg::BANK_REGS; b++) chips_reg[b] = 4'd1;
            bank_count_reg = 3'd0;
            pending_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == bsroc_pkg::CFG_BANK_TOTAL)
                    bank_count_reg = cfg_wdata[2:0];
                else if (cfg_index >= bsroc_pkg::CFG_BANK0_CHIPS &&
                         int'(cfg_index) < int'(bsroc_pkg::CFG_BANK0_CHIPS) + bsroc_pkg::BANK_REGS)
                    chips_reg[cfg_index - bsroc_pkg::CFG_BANK0_CHIPS] = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                model_request(bsroc_pkg::opcode_t'(s_tuser), s_tdata[1:0], s_tdata[3:2],
                              s_tdata[9:4], s_tdata[12:10], s_tdata[13], s_tdata[21:14],
                              s_tdata[22]);
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, actual tdata=%h tuser=%b tlast=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", int'(want.status), int'(m_tdata[2:0]));
                    compare_field("result_value", int'(want.value), int'(m_tdata[10:3]));
                    compare_field("is_shift_bit", int'(want.shift), int'(m_tuser));
                    compare_field("bank_line", int'(want.line), int'(m_tdata[12:11]));
                    compare_field("serial_bit", int'(want.sbit), int'(m_tdata[13]));
                    compare_field("latch_pulse", int'(want.latch), int'(m_tdata[14]));
                    compare_field("last", int'(want.last), int'(m_tlast));
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

>>> bench/tb_top.sv
// ============================================================================
// tb_top
// Drives requests and bank settings into the banked shift register output
// controller: a directed pass over every operation and error case, then
// random requests under a series of bank layouts, with random gaps and
// stalls on both streams. The checker beside the block predicts and compares.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_REQUESTS = 32;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [2:0]                      cfg_index = '0;
    logic [3:0]                      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [bsroc_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [bsroc_pkg::S_TUSER_W-1:0] s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [bsroc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    int   fail_count;
    int   outstanding;
    int   quiet_cycles = 0;
    logic no_idle = 1'b0;

    banked_shift_register_output_controller dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    bsroc_checker u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .fail_count, .outstanding
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side stalls about a quarter of the time.
    always @(negedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end

    // Stop the run if no request, result or register write moves for too long.
    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready) && !cfg_we)
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(bsroc_pkg::opcode_t op, logic [1:0] bf, logic [1:0] bl,
                                logic [5:0] pin, logic [2:0] chip, logic lvl,
                                logic [7:0] val, logic msb);
        while (!no_idle && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, msb, val, lvl, chip, pin, bl, bf};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Mostly in-range banks and low pins, so the layout is exercised deeply.
    task automatic random_request();
        logic [1:0] bf;
        logic [1:0] bl;
        logic [5:0] pin;
        logic [2:0] chip;
        bf   = 2'($urandom_range(0, 3));
        bl   = ($urandom_range(0, 99) < 80) ? 2'($urandom_range(bf, 3))
                                            : 2'($urandom_range(0, 3));
        pin  = ($urandom_range(0, 99) < 60) ? 6'($urandom_range(0, 31))
                                            : 6'($urandom_range(0, 63));
        chip = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(0, 3))
                                            : 3'($urandom_range(0, 7));
        send_request(bsroc_pkg::opcode_t'(4'($urandom_range(0, 15))), bf, bl, pin, chip,
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    // Hold off new requests until every result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (8) @(negedge aclk);
    endtask

    // Write the bank count and all four bank sizes.
    task automatic apply_layout(logic [2:0] nb, logic [3:0] c0, logic [3:0] c1,
                                logic [3:0] c2, logic [3:0] c3);
        logic [3:0] sizes [bsroc_pkg::BANK_REGS];
        sizes = '{c0, c1, c2, c3};
        cfg_we    <= 1'b1;
        cfg_index <= bsroc_pkg::CFG_BANK_TOTAL;
        cfg_wdata <= {1'b0, nb};
        @(negedge aclk);
        for (int i = 0; i < bsroc_pkg::BANK_REGS; i++) begin
            cfg_index <= bsroc_pkg::CFG_BANK0_CHIPS + 3'(i);
            cfg_wdata <= sizes[i];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] random_size();
        return ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // No banks defined after reset: everything but whole-image requests fails.
        send_request(bsroc_pkg::OP_READ_PIN,    2'd0, 2'd0, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_SET_BPIN,    2'd0, 2'd0, 6'd0,  3'd0, 1'b1, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_SHIFT,       2'd0, 2'd0, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_BANK_OF_PIN, 2'd0, 2'd0, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_SET_ALL,     2'd0, 2'd0, 6'd0,  3'd0, 1'b1, 8'h00, 1'b0);
        settle();

        // Four banks of two chips fill the whole image.
        apply_layout(3'd4, 4'd2, 4'd2, 4'd2, 4'd2);
        send_request(bsroc_pkg::OP_SHIFT,       2'd0, 2'd3, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_INV_ALL,     2'd0, 2'd0, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_SET_PIN,     2'd0, 2'd0, 6'd63, 3'd0, 1'b1, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_INV_PIN,     2'd0, 2'd0, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_READ_PIN,    2'd0, 2'd0, 6'd63, 3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_SET_BANKS,   2'd1, 2'd2, 6'd0,  3'd0, 1'b1, 8'h00, 1'b0);
        // Reversed range.
        send_request(bsroc_pkg::OP_INV_BANKS,   2'd2, 2'd1, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_SET_BPIN,    2'd3, 2'd0, 6'd15, 3'd0, 1'b0, 8'h00, 1'b0);
        // A bank-relative pin that lands in a later bank, then one past the end.
        send_request(bsroc_pkg::OP_INV_BPIN,    2'd1, 2'd0, 6'd40, 3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_READ_BPIN,   2'd2, 2'd0, 6'd63, 3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_WRITE_CHIP,  2'd3, 2'd0, 6'd0,  3'd1, 1'b0, 8'ha5, 1'b0);
        send_request(bsroc_pkg::OP_WRITE_CHIP,  2'd0, 2'd0, 6'd0,  3'd7, 1'b0, 8'hff, 1'b0);
        send_request(bsroc_pkg::OP_INV_CHIP,    2'd1, 2'd0, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_READ_CHIP,   2'd3, 2'd0, 6'd0,  3'd1, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_BANK_OF_PIN, 2'd0, 2'd0, 6'd47, 3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_PIN_COUNT,   2'd2, 2'd0, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);
        send_request(bsroc_pkg::OP_SHIFT,       2'd2, 2'd3, 6'd0,  3'd0, 1'b0, 8'h00, 1'b1);
        send_request(bsroc_pkg::OP_SHIFT,       2'd3, 2'd3, 6'd0,  3'd0, 1'b0, 8'h00, 1'b0);

        // Random requests under a sequence of bank layouts.
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            case (phase)
                0: apply_layout(3'd4, 4'd1,  4'd1, 4'd1, 4'd1);
                1: apply_layout(3'd1, 4'd8,  4'd1, 4'd1, 4'd1);
                2: apply_layout(3'd7, 4'd3,  4'd4, 4'd2, 4'd1);
                3: apply_layout(3'd3, 4'd1,  4'd0, 4'd5, 4'd1);
                4: apply_layout(3'd4, 4'd15, 4'd2, 4'd2, 4'd2);
                5: apply_layout(3'd0, 4'd8,  4'd8, 4'd8, 4'd8);
                default: apply_layout(3'($urandom_range(0, 7)), random_size(), random_size(),
                                      random_size(), random_size());
            endcase
            // The first random phase runs without gaps or stalls.
            no_idle = (phase == 0);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n == PHASE_REQUESTS / 2) wait_drained();
                random_request();
            end
        end

        settle();
        repeat (24) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bsroc_pkg.sv
hw/rtl/bsroc_layout.sv
hw/rtl/bsroc_shifter.sv
hw/rtl/banked_shift_register_output_controller.sv
bench/bsroc_checker.sv
bench/tb_top.sv
